// ----- sv/dtx_pkg.sv -----
`timescale 1ns / 1ps

package dtx_pkg;

  // Buffer geometry
  localparam int SID_BUF_BYTES = 64;
  localparam int SID_AW        = $clog2(SID_BUF_BYTES);
  localparam int LEN_W         = 7;   // length and payload_size field width
  localparam int FN_W          = 32;
  localparam int BYTE_W        = 8;

  // 104-frame multiframe position
  localparam int MF_LEN  = 104;
  localparam int REM_W   = 7;
  localparam int SCHED_N = 8;

  // fn mod 104 = 8 * ((fn >> 3) mod 13) + (fn & 7); 2^12 is 1 mod 13, so
  // 12-bit chunks of fn >> 3 are summed and folded, then a reciprocal finishes
  localparam int MF_LOW_W = 3;
  localparam int MF_SUB   = MF_LEN / 8;
  localparam int SUB_W    = REM_W - MF_LOW_W;
  localparam int CHUNK_W  = 12;
  localparam int FOLD_W   = 14;
  localparam int RECIP_W  = 14;
  localparam int RECIP_SH = 17;
  localparam int PROD_W   = FOLD_W - 1 + RECIP_W;
  localparam int QUO_W    = PROD_W - RECIP_SH;
  localparam logic [RECIP_W-1:0] MF_SUB_RECIP = 14'd10083;  // ceil(2^17 / 13)
  localparam int MOD_CW   = 2;

  // AMR minimum distance from the stored frame
  localparam logic [FN_W-1:0] AMR_UPDATE_GAP = FN_W'(7);
  localparam logic [FN_W-1:0] AMR_FIRST_GAP  = FN_W'(3);

  // Configuration port
  localparam int CFG_W  = 2;
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] CFG_SPEECH_MODE   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_FULL_RATE     = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_HALF_SUBCHAN  = 2'd2;

  // Speech modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_FR   = 2'd1;
  localparam logic [1:0] MODE_EFR  = 2'd2;
  localparam logic [1:0] MODE_AMR  = 2'd3;

  // Input actions and result kinds
  localparam logic ACT_STORE    = 1'b0;
  localparam logic ACT_REQUEST  = 1'b1;
  localparam logic KIND_SID     = 1'b0;
  localparam logic KIND_NO_DATA = 1'b1;

  // Mandatory repetition positions within the multiframe
  localparam logic [REM_W-1:0] SCHED_FULL [SCHED_N] =
    '{7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd58, 7'd59};
  localparam logic [REM_W-1:0] SCHED_HALF0 [SCHED_N] =
    '{7'd0, 7'd2, 7'd4, 7'd6, 7'd52, 7'd54, 7'd56, 7'd58};
  localparam logic [REM_W-1:0] SCHED_HALF1 [SCHED_N] =
    '{7'd14, 7'd16, 7'd18, 7'd20, 7'd66, 7'd68, 7'd70, 7'd72};

  // Commands from controller to datapath
  typedef struct packed {
    logic take;         // input word accepted this cycle
    logic mod_start;    // load frame number into the mod-104 unit
    logic mod_step;     // one remainder step
    logic rd_start;     // read buffer byte 0
    logic rd_next;      // read next buffer byte
    logic load_out;     // load output register from buffer read data
    logic load_marker;  // load output register with the no-data marker
  } dtx_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       len_zero;
    logic       too_soon;
    logic       sched_hit;
    logic       mod_done;
    logic       out_last;
  } dtx_stat_t;

  // True when the multiframe position is in the selected schedule
  function automatic logic in_sched(logic full_rate, logic sub, logic [REM_W-1:0] pos);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SCHED_N; i++) begin
      if (full_rate) begin
        if (pos == SCHED_FULL[i]) hit = 1'b1;
      end else if (sub) begin
        if (pos == SCHED_HALF1[i]) hit = 1'b1;
      end else begin
        if (pos == SCHED_HALF0[i]) hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ----- sv/dtx_ram.sv -----
`timescale 1ns / 1ps

module dtx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/dtx_mod104.sv -----
`timescale 1ns / 1ps

module dtx_mod104
  import dtx_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             step_i,
  input  logic [FN_W-1:0]  value_i,
  output logic             done_o,
  output logic [REM_W-1:0] rem_o
);

  localparam logic [MOD_CW-1:0] MS_FOLD = 2'd0;
  localparam logic [MOD_CW-1:0] MS_QUO  = 2'd1;
  localparam logic [MOD_CW-1:0] MS_REM  = 2'd2;

  logic [MF_LOW_W-1:0] low_q, low_d;
  logic [FOLD_W-1:0]   acc_q, acc_d;
  logic [QUO_W-1:0]    quo_q, quo_d;
  logic [REM_W-1:0]    rem_q, rem_d;
  logic [MOD_CW-1:0]   cnt_q, cnt_d;
  logic [PROD_W-1:0]   prod;
  logic [FOLD_W-2:0]   diff;

  // Start sums the chunks; steps fold, take the quotient, form the remainder
  always_comb begin
    low_d = low_q;
    acc_d = acc_q;
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    prod  = PROD_W'(acc_q[FOLD_W-2:0]) * PROD_W'(MF_SUB_RECIP);
    diff  = acc_q[FOLD_W-2:0] - (FOLD_W-1)'(quo_q) * (FOLD_W-1)'(MF_SUB);
    if (start_i) begin
      low_d = value_i[MF_LOW_W-1:0];
      acc_d = FOLD_W'(value_i[MF_LOW_W +: CHUNK_W]) +
              FOLD_W'(value_i[MF_LOW_W+CHUNK_W +: CHUNK_W]) +
              FOLD_W'(value_i[FN_W-1:MF_LOW_W+2*CHUNK_W]);
      cnt_d = '0;
    end else if (step_i) begin
      case (cnt_q)
        MS_FOLD: acc_d = FOLD_W'(acc_q[CHUNK_W-1:0]) + FOLD_W'(acc_q[FOLD_W-1:CHUNK_W]);
        MS_QUO:  quo_d = prod[PROD_W-1:RECIP_SH];
        default: rem_d = {diff[SUB_W-1:0], low_q};
      endcase
      cnt_d = cnt_q + MOD_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q <= low_d;
    acc_q <= acc_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // Final step is the one that forms the remainder
  assign done_o = (cnt_q == MS_REM);
  assign rem_o  = rem_q;

endmodule

// ----- sv/dtx_datapath.sv -----
`timescale 1ns / 1ps

module dtx_datapath
  import dtx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtx_cmd_t          cmd_i,
  output dtx_stat_t         stat_o,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              action_i,
  input  logic [FN_W-1:0]   frame_number_i,
  input  logic [BYTE_W-1:0] sid_byte_i,
  input  logic              sid_last_i,
  input  logic              sid_is_update_i,
  output logic              result_kind_o,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic [LEN_W-1:0]  payload_size_o,
  output logic              last_of_run_o
);

  // Configuration registers
  logic [1:0] mode_q;
  logic       full_rate_q;
  logic       half_sub_q;

  // Frame bookkeeping
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  wpos_q, wpos_d;
  logic [FN_W-1:0]   sid_fn_q, sid_fn_d;
  logic              upd_q, upd_d;
  logic [FN_W-1:0]   req_fn_q;
  logic [SID_AW-1:0] rd_idx_q, rd_idx_d;

  // Output register
  logic              kind_q;
  logic [BYTE_W-1:0] byte_q;
  logic [LEN_W-1:0]  size_q;
  logic              last_q;

  logic              wr_en;
  logic [LEN_W-1:0]  wpos_inc;
  logic              rd_en;
  logic [SID_AW-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [FN_W-1:0]   gap;
  logic              mod_done;
  logic [REM_W-1:0]  mod_rem;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NONE;
      full_rate_q <= 1'b1;
      half_sub_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SPEECH_MODE:  mode_q      <= cfg_data_i;
        CFG_FULL_RATE:    full_rate_q <= cfg_data_i[0];
        CFG_HALF_SUBCHAN: half_sub_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Store path: write at the fill position, commit on the last byte
  assign wr_en    = cmd_i.take && (action_i == ACT_STORE) &&
                    (wpos_q != LEN_W'(SID_BUF_BYTES));
  assign wpos_inc = wpos_q + LEN_W'(wr_en);

  always_comb begin
    wpos_d   = wpos_q;
    len_d    = len_q;
    sid_fn_d = sid_fn_q;
    upd_d    = upd_q;
    if (cmd_i.take && (action_i == ACT_STORE)) begin
      wpos_d = wpos_inc;
      if (sid_last_i) begin
        len_d    = wpos_inc;
        sid_fn_d = frame_number_i;
        upd_d    = sid_is_update_i;
        wpos_d   = '0;
      end
    end
  end

  // Replay read index
  always_comb begin
    rd_idx_d = rd_idx_q;
    rd_addr  = rd_idx_q;
    rd_en    = 1'b0;
    if (cmd_i.rd_start) begin
      rd_idx_d = '0;
      rd_addr  = '0;
      rd_en    = 1'b1;
    end else if (cmd_i.rd_next) begin
      rd_idx_d = rd_idx_q + SID_AW'(1);
      rd_addr  = rd_idx_q + SID_AW'(1);
      rd_en    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      wpos_q   <= '0;
      sid_fn_q <= '0;
      upd_q    <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      len_q    <= len_d;
      wpos_q   <= wpos_d;
      sid_fn_q <= sid_fn_d;
      upd_q    <= upd_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // Request frame number and output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_fn_q <= frame_number_i;
    end
    if (cmd_i.load_marker) begin
      kind_q <= KIND_NO_DATA;
      byte_q <= '0;
      size_q <= '0;
      last_q <= 1'b1;
    end else if (cmd_i.load_out) begin
      kind_q <= KIND_SID;
      byte_q <= rd_data;
      size_q <= len_q + LEN_W'(1);
      last_q <= (LEN_W'(rd_idx_q) + LEN_W'(1)) == len_q;
    end
  end

  dtx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SID_BUF_BYTES)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wpos_q[SID_AW-1:0]),
    .wdata_i (sid_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  dtx_mod104 u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mod_start),
    .step_i  (cmd_i.mod_step),
    .value_i (req_fn_q),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // Status toward the controller
  assign gap = req_fn_q - sid_fn_q;

  always_comb begin
    stat_o.mode      = mode_q;
    stat_o.len_zero  = (len_q == '0);
    stat_o.too_soon  = upd_q ? (gap < AMR_UPDATE_GAP) : (gap < AMR_FIRST_GAP);
    stat_o.sched_hit = in_sched(full_rate_q, half_sub_q, mod_rem);
    stat_o.mod_done  = mod_done;
    stat_o.out_last  = last_q;
  end

  assign result_kind_o  = kind_q;
  assign payload_byte_o = byte_q;
  assign payload_size_o = size_q;
  assign last_of_run_o  = last_q;

endmodule

// ----- sv/dtx_ctrl.sv -----
`timescale 1ns / 1ps

module dtx_ctrl
  import dtx_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      action_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dtx_cmd_t  cmd_o,
  input  dtx_stat_t stat_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_SEND   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      // Take words; stores finish here, requests move on
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
        if (in_valid_i && (action_i == ACT_REQUEST)) begin
          state_d = S_DECIDE;
        end
      end
      // Per-mode repetition rule
      S_DECIDE: begin
        case (stat_i.mode)
          MODE_AMR: begin
            if (stat_i.too_soon) begin
              state_d = S_IDLE;
            end else if (stat_i.len_zero) begin
              cmd_o.load_marker = 1'b1;
              state_d           = S_SEND;
            end else begin
              cmd_o.rd_start = 1'b1;
              state_d        = S_LOAD;
            end
          end
          MODE_FR: begin
            cmd_o.mod_start = 1'b1;
            state_d         = S_MOD;
          end
          MODE_EFR: begin
            if (stat_i.len_zero) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.rd_start = 1'b1;
              state_d        = S_LOAD;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      // Frame number mod 104
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.sched_hit && !stat_i.len_zero) begin
          cmd_o.rd_start = 1'b1;
          state_d        = S_LOAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      // Buffer read data into the output register
      S_LOAD: begin
        cmd_o.load_out = 1'b1;
        state_d        = S_SEND;
      end
      // Hold the word until taken, then fetch the next byte or, after the last, go idle
      S_SEND: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (stat_i.out_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = S_LOAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/dtx_sid_repeat_scheduler.sv -----
`timescale 1ns / 1ps

// Channel  | Handshake                         | Payload
// ---------+-----------------------------------+------------------------------------------
// input    | in_valid_i / in_stall_o           | action, frame_number, sid_byte, sid_last,
//          |                                   | sid_is_update
// output   | out_valid_o / out_stall_i         | result_kind, payload_byte, payload_size,
//          |                                   | last_of_run
// config   | cfg_we_i, cfg_index_i, cfg_data_i | speech_mode, full_rate_channel,
//          |                                   | half_subchannel
//
// A store word is accepted while idle. A request is accepted, then decided; FR mode
// then adds 3 steps of the mod-104 unit and the table check. Each result word passes
// the buffer RAM read and the output register and is held while the output is
// stalled; the AMR no-data marker is ready after the decision. Input is stalled
// from a request until its last word is taken, or until the decision if none is
// sent. Reset clears control state and configuration; the buffer RAM is not cleared.

module dtx_sid_repeat_scheduler
  import dtx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [FN_W-1:0]   frame_number_i,
  input  logic [BYTE_W-1:0] sid_byte_i,
  input  logic              sid_last_i,
  input  logic              sid_is_update_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              result_kind_o,
  output logic [BYTE_W-1:0] payload_byte_o,
  output logic [LEN_W-1:0]  payload_size_o,
  output logic              last_of_run_o,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  dtx_cmd_t  cmd;
  dtx_stat_t stat;

  dtx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  dtx_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .action_i        (action_i),
    .frame_number_i  (frame_number_i),
    .sid_byte_i      (sid_byte_i),
    .sid_last_i      (sid_last_i),
    .sid_is_update_i (sid_is_update_i),
    .result_kind_o   (result_kind_o),
    .payload_byte_o  (payload_byte_o),
    .payload_size_o  (payload_size_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// ----- verif/dtx_sid_repeat_scheduler_tb.sv -----
`timescale 1ns / 1ps

module dtx_sid_repeat_scheduler_tb;
  import dtx_pkg::*;

  // Index past the last register, the block must ignore it
  localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 64;

  // One input word and one filler word
  typedef struct {
    logic              action;
    logic [FN_W-1:0]   fn;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              upd;
  } sid_word_t;

  typedef struct {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  size;
    logic              last;
  } filler_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              action_i = ACT_STORE;
  logic [FN_W-1:0]   frame_number_i = '0;
  logic [BYTE_W-1:0] sid_byte_i = '0;
  logic              sid_last_i = 1'b0;
  logic              sid_is_update_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              result_kind_o;
  logic [BYTE_W-1:0] payload_byte_o;
  logic [LEN_W-1:0]  payload_size_o;
  logic              last_of_run_o;
  logic              cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;

  dtx_sid_repeat_scheduler dut (.*);

  always #10 clk_i = ~clk_i;

  sid_word_t word_q[$];
  filler_t   filler_q[$];
  sid_word_t cur_word;
  int        fail_cnt = 0;
  int        send_wait = 0;
  int        recv_wait = 0;
  bit        send_idle = 1'b0;
  bit        recv_idle = 1'b0;

  // Shadow of the block: SID store and registers
  logic [BYTE_W-1:0] sid_mem [SID_BUF_BYTES];
  int                sid_len = 0;
  int                wr_pos = 0;
  logic [FN_W-1:0]   sid_fn = '0;
  logic              sid_upd = 1'b0;
  logic [1:0]        mode_reg = MODE_NONE;
  logic              fr_reg = 1'b1;
  logic              sub_reg = 1'b0;

  // Frame number of the last complete frame handed to the driver
  logic [FN_W-1:0]   gen_fn = '0;

  function automatic int draw_gap(bit busy);
    return busy ? $urandom_range(0, 7) : 0;
  endfunction

  // Expect the stored frame to be sent again, byte by byte
  task automatic replay_sid();
    filler_t f;
    int      n;
    n = (sid_len > SID_BUF_BYTES) ? SID_BUF_BYTES : sid_len;
    for (int k = 0; k < n; k++) begin
      f.kind = KIND_SID;
      f.data = sid_mem[k];
      f.size = LEN_W'(sid_len + 1);
      f.last = (k == n - 1);
      filler_q.push_back(f);
    end
  endtask

  // Update the shadow for one accepted word and queue the filler it causes
  task automatic track_word(input sid_word_t w);
    logic [FN_W-1:0]  gap;
    logic [REM_W-1:0] pos;
    logic             hit;
    filler_t          f;
    if (w.action == ACT_STORE) begin
      if (wr_pos < SID_BUF_BYTES) begin
        sid_mem[wr_pos] = w.data;
        wr_pos++;
      end
      if (w.last) begin
        sid_len = wr_pos;
        sid_fn = w.fn;
        sid_upd = w.upd;
        wr_pos = 0;
      end
    end else begin
      case (mode_reg)
        MODE_AMR: begin
          gap = w.fn - sid_fn;
          if (gap >= (sid_upd ? AMR_UPDATE_GAP : AMR_FIRST_GAP)) begin
            if (sid_len != 0) begin
              replay_sid();
            end else begin
              f.kind = KIND_NO_DATA;
              f.data = '0;
              f.size = '0;
              f.last = 1'b1;
              filler_q.push_back(f);
            end
          end
        end
        MODE_FR: begin
          pos = REM_W'(w.fn % 32'd104);
          hit = 1'b0;
          for (int i = 0; i < SCHED_N; i++) begin
            if (fr_reg) begin
              if (pos == SCHED_FULL[i]) hit = 1'b1;
            end else if (sub_reg) begin
              if (pos == SCHED_HALF1[i]) hit = 1'b1;
            end else begin
              if (pos == SCHED_HALF0[i]) hit = 1'b1;
            end
          end
          if (hit) replay_sid();
        end
        MODE_EFR: replay_sid();
        default: ;
      endcase
    end
  endtask

  // Input driver
  always @(posedge clk_i) begin : drive_p
    logic slot_free;
    if (rst_ni) begin
      slot_free = !in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        track_word(cur_word);
        slot_free = 1'b1;
        send_wait = draw_gap(send_idle);
      end
      if (slot_free) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid_i <= 1'b0;
        end else if (word_q.size() != 0) begin
          cur_word = word_q.pop_front();
          in_valid_i <= 1'b1;
          action_i <= cur_word.action;
          frame_number_i <= cur_word.fn;
          sid_byte_i <= cur_word.data;
          sid_last_i <= cur_word.last;
          sid_is_update_i <= cur_word.upd;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and checker
  always @(posedge clk_i) begin : check_p
    filler_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (filler_q.size() == 0) begin
          $error("unexpected word: kind %0d byte %0d size %0d last %0d",
                 result_kind_o, payload_byte_o, payload_size_o, last_of_run_o);
          fail_cnt++;
        end else begin
          want = filler_q.pop_front();
          if (result_kind_o !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, result_kind_o);
            fail_cnt++;
          end
          if (payload_byte_o !== want.data) begin
            $error("payload_byte: expected %0d, got %0d", want.data, payload_byte_o);
            fail_cnt++;
          end
          if (payload_size_o !== want.size) begin
            $error("payload_size: expected %0d, got %0d", want.size, payload_size_o);
            fail_cnt++;
          end
          if (last_of_run_o !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, last_of_run_o);
            fail_cnt++;
          end
        end
        recv_wait = draw_gap(recv_idle);
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_stall_i <= (recv_wait != 0);
    end
  end

  task automatic push_store(input logic [BYTE_W-1:0] data, input logic last,
                            input logic upd, input logic [FN_W-1:0] fn);
    sid_word_t w;
    w.action = ACT_STORE;
    w.fn = fn;
    w.data = data;
    w.last = last;
    w.upd = upd;
    if (last) gen_fn = fn;
    word_q.push_back(w);
  endtask

  // Store-only fields of a request carry noise
  task automatic push_request(input logic [FN_W-1:0] fn);
    sid_word_t w;
    w.action = ACT_REQUEST;
    w.fn = fn;
    w.data = BYTE_W'($urandom());
    w.last = 1'($urandom_range(0, 1));
    w.upd = 1'($urandom_range(0, 1));
    word_q.push_back(w);
  endtask

  task automatic push_frame(input int len, input logic upd, input logic [FN_W-1:0] fn);
    for (int i = 0; i < len; i++)
      push_store(BYTE_W'($urandom()), i == len - 1, upd, (i == len - 1) ? fn : $urandom());
  endtask

  // Request frame numbers near the last generated frame, on or next to schedule positions, or at random
  function automatic logic [FN_W-1:0] pick_fn();
    logic [REM_W-1:0] pos;
    case ($urandom_range(0, 3))
      0: return gen_fn + $urandom_range(0, 12);
      1: begin
        case ($urandom_range(0, 2))
          0:       pos = SCHED_FULL[$urandom_range(0, 7)];
          1:       pos = SCHED_HALF0[$urandom_range(0, 7)];
          default: pos = SCHED_HALF1[$urandom_range(0, 7)];
        endcase
        return 32'($urandom_range(0, 41297761)) * 32'd104 + pos + $urandom_range(0, 1);
      end
      default: return $urandom();
    endcase
  endfunction

  // Mostly complete frames followed by requests; some lone requests and
  // requests that land inside a frame
  task automatic random_traffic(input int n_words, input int long_len);
    int               cnt;
    int               len;
    int               sel;
    logic [FN_W-1:0]  fn;
    cnt = 0;
    if (long_len != 0) begin
      push_frame(long_len, 1'($urandom_range(0, 1)), $urandom());
      push_request(pick_fn());
      cnt = long_len + 1;
    end
    while (cnt < n_words) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(17, 40);
          1, 2, 3: len = $urandom_range(9, 16);
          default: len = $urandom_range(1, 8);
        endcase
        fn = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                         : $urandom();
        push_frame(len, 1'($urandom_range(0, 1)), fn);
        cnt += len;
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) push_request(pick_fn());
        cnt += len;
      end else if (sel < 8) begin
        push_request(pick_fn());
        cnt++;
      end else begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) push_store(BYTE_W'($urandom()), 1'b0, 1'b0, $urandom());
        push_request(pick_fn());
        push_store(BYTE_W'($urandom()), 1'b1, 1'($urandom_range(0, 1)), $urandom());
        cnt += len + 2;
      end
    end
  endtask

  // Wait until every word is in and every filler is out, then let the block settle
  task automatic wait_drained();
    while (word_q.size() != 0 || in_valid_i || filler_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_SPEECH_MODE:  mode_reg = val;
      CFG_FULL_RATE:    fr_reg = val[0];
      CFG_HALF_SUBCHAN: sub_reg = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // New register setting and idling style, only once the block is quiet
  task automatic set_regs(input logic [1:0] mode, input logic fr, input logic sub);
    wait_drained();
    send_idle = ($urandom_range(0, 3) != 0);
    recv_idle = ($urandom_range(0, 3) != 0);
    write_reg(CFG_SPEECH_MODE, mode);
    write_reg(CFG_FULL_RATE, {1'($urandom_range(0, 1)), fr});
    write_reg(CFG_HALF_SUBCHAN, {1'($urandom_range(0, 1)), sub});
    if ($urandom_range(0, 1) != 0) write_reg(CFG_SPARE, CFG_W'($urandom()));
  endtask

  // Stimulus
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty buffer: FR and EFR stay silent
    set_regs(MODE_EFR, 1'b1, 1'b0);
    push_request(32'd52);
    set_regs(MODE_FR, 1'b1, 1'b0);
    push_request(32'd52);

    // AMR: empty buffer marker, too soon after first and update, wrapped distance
    set_regs(MODE_AMR, 1'b0, 1'b1);
    push_request(32'd2);
    push_request(32'd3);
    push_request(32'hFFFF_FFFF);
    push_store(8'h00, 1'b0, 1'b0, $urandom());
    push_store(8'hFF, 1'b0, 1'b0, $urandom());
    push_store(8'hA5, 1'b1, 1'b1, 32'd100);
    push_request(32'd106);
    push_request(32'd107);
    push_request(32'd99);
    push_store(8'h5A, 1'b1, 1'b0, 32'hFFFF_FFFE);
    push_request(32'd0);
    push_request(32'd1);

    // FR schedules: hits and near misses on each table
    set_regs(MODE_FR, 1'b1, 1'b0);
    push_request(32'd52);
    push_request(32'd371);
    push_request(32'd51);
    push_request(32'd60);
    push_request(32'hFFFF_FFFF);
    set_regs(MODE_FR, 1'b0, 1'b0);
    push_request(32'd0);
    push_request(32'd58);
    push_request(32'd1);
    set_regs(MODE_FR, 1'b0, 1'b1);
    push_request(32'd14);
    push_request(32'd72);
    push_request(32'd0);

    // EFR with a request inside a frame, then no speech
    set_regs(MODE_EFR, 1'b1, 1'b1);
    push_store(8'h11, 1'b0, 1'b0, $urandom());
    push_request($urandom());
    push_store(8'h22, 1'b1, 1'b1, $urandom());
    push_request($urandom());
    set_regs(MODE_NONE, 1'b1, 1'b0);
    push_request($urandom());

    // Random traffic across settings; the EFR run opens with an overlong frame
    set_regs(MODE_AMR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    random_traffic(12, 0);
    set_regs(MODE_FR, 1'b1, 1'($urandom_range(0, 1)));
    random_traffic(8, 0);
    set_regs(MODE_FR, 1'b0, 1'b0);
    random_traffic(8, 0);
    set_regs(MODE_FR, 1'b0, 1'b1);
    random_traffic(8, 0);
    set_regs(MODE_EFR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    random_traffic(8, 66);
    set_regs(MODE_NONE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    random_traffic(4, 0);
    for (int p = 0; p < 3; p++) begin
      set_regs(2'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      random_traffic(4, 0);
    end

    wait_drained();
    if (fail_cnt == 0) begin
      $display("dtx_sid_repeat_scheduler_tb: clean");
    end else begin
      $display("dtx_sid_repeat_scheduler_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("dtx_sid_repeat_scheduler_tb: errors");
    $finish;
  end

endmodule
